FILE: src/oriented_box_extent_defines.svh
// Assertion macros for the oriented box extent block.
// Taken by `include in files that check their own logic; no other dependencies.
`ifndef ORIENTED_BOX_EXTENT_DEFINES_SVH
`define ORIENTED_BOX_EXTENT_DEFINES_SVH
`ifndef SYNTH
// Uses clk and arst_n of the including module.
`define OBE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("oriented_box_extent: assertion failed");
`define OBE_ASSERT_IMPL(lbl, ante, cons) `OBE_ASSERT(lbl, (ante) |-> (cons))
`define OBE_ASSERT_NEXT(lbl, ante, cons) `OBE_ASSERT(lbl, (ante) |=> (cons))
`else
`define OBE_ASSERT(lbl, prop)
`define OBE_ASSERT_IMPL(lbl, ante, cons)
`define OBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/obe_pkg.sv
// Shared widths, register codes, reset values and types of the oriented box extent block.
// No dependencies; the block's modules and the testbench refer to it by scoped names.
package obe_pkg;

	localparam int FRAC_W     = 16;
	localparam int AXIS_W     = 18;
	localparam int AXES_W     = 3 * AXIS_W;
	localparam int CENTRE_W   = 63;
	localparam int MARGIN_W   = 16;
	localparam int BOUND_W    = 24;
	localparam int SIZE_W     = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_U     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_V     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_W     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_CENTRE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd4;

	localparam logic [AXES_W-1:0]   AXIS_U_RST = 54'd65536;
	localparam logic [AXES_W-1:0]   AXIS_V_RST = 54'd4294967296;
	localparam logic [AXES_W-1:0]   AXIS_W_RST = 54'd281474976710656;
	localparam logic [CENTRE_W-1:0] CENTRE_RST = '0;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd3277;

	localparam logic [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};
	localparam logic [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};
	localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [2:0][BOUND_W-1:0] bound3_t;

	typedef struct packed {
		logic [AXES_W-1:0]   axis_u;
		logic [AXES_W-1:0]   axis_v;
		logic [AXES_W-1:0]   axis_w;
		logic [CENTRE_W-1:0] centre;
		logic [MARGIN_W-1:0] margin;
	} cfg_t;

	typedef struct packed {
		bound3_t lo;
		bound3_t hi;
	} box_bounds_t;

	// Component j (x, y, z) of a packed axis register.
	function automatic axis_t axis_comp(input logic [AXES_W-1:0] a, input int j);
		return a[j*AXIS_W +: AXIS_W];
	endfunction

endpackage

FILE: src/points_if.sv
// Point input channel: valid/ready handshake with three coordinates and a last flag.
// Depends on nothing; width follows COORD_WIDTH.
interface points_if #(parameter int COORD_WIDTH = 21);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic                          last_point;

	modport source(output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink(input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

FILE: src/box_if.sv
// Box result channel: valid/ready handshake with centre, sizes and widened bounds.
// Depends on nothing; centre width follows COORD_WIDTH.
interface box_if #(parameter int COORD_WIDTH = 21);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] new_centre_x;
	logic signed [COORD_WIDTH-1:0] new_centre_y;
	logic signed [COORD_WIDTH-1:0] new_centre_z;
	logic [21:0]                   size_u;
	logic [21:0]                   size_v;
	logic signed [23:0]            low_u;
	logic signed [23:0]            low_v;
	logic signed [23:0]            low_w;
	logic signed [23:0]            high_u;
	logic signed [23:0]            high_v;
	logic signed [23:0]            high_w;

	modport source(output valid, new_centre_x, new_centre_y, new_centre_z, size_u, size_v,
		low_u, low_v, low_w, high_u, high_v, high_w, input ready);
	modport sink(input valid, new_centre_x, new_centre_y, new_centre_z, size_u, size_v,
		low_u, low_v, low_w, high_u, high_v, high_w, output ready);
endinterface

FILE: src/cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
// Depends on nothing.
interface cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/oriented_box_extent.sv
// Top level of the oriented box extent block: configuration registers and the three units.
// Depends on obe_pkg, points_if, box_if, cfg_if, obe_project, obe_bounds and obe_recentre.
//
// Points enter one per clock cycle and flow through a six-register pipeline: input register,
// axis products, rounded projections, running bounds, recentring products, result register.
// Each last point that is taken gives one result item at the result register; other points give none.
// The input stalls only when a result is held at the output and the stages behind it fill,
// or when a last point finds the bounds stage still occupied. Configuration writes are taken
// at any time (ready is always high), but most stages read the live registers, so write
// them only while no item is in flight.
module oriented_box_extent #(
	parameter int COORD_WIDTH = 21
) (
	input  logic  clk,
	input  logic  arst_n,
	points_if.sink pts,
	box_if.source  box,
	cfg_if.sink    cfg
);
	obe_pkg::cfg_t        cfg_q;
	logic                 p_valid, p_ready, p_last;
	obe_pkg::bound3_t     proj;
	logic                 b_valid, b_ready;
	obe_pkg::box_bounds_t bb;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_u <= obe_pkg::AXIS_U_RST;
			cfg_q.axis_v <= obe_pkg::AXIS_V_RST;
			cfg_q.axis_w <= obe_pkg::AXIS_W_RST;
			cfg_q.centre <= obe_pkg::CENTRE_RST;
			cfg_q.margin <= obe_pkg::MARGIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				obe_pkg::REG_AXIS_U:     cfg_q.axis_u <= cfg.data[obe_pkg::AXES_W-1:0];
				obe_pkg::REG_AXIS_V:     cfg_q.axis_v <= cfg.data[obe_pkg::AXES_W-1:0];
				obe_pkg::REG_AXIS_W:     cfg_q.axis_w <= cfg.data[obe_pkg::AXES_W-1:0];
				obe_pkg::REG_BOX_CENTRE: cfg_q.centre <= cfg.data[obe_pkg::CENTRE_W-1:0];
				obe_pkg::REG_MARGIN:     cfg_q.margin <= cfg.data[obe_pkg::MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	obe_project #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_project (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts),
		.cfg    (cfg_q),
		.p_valid(p_valid),
		.p_ready(p_ready),
		.proj   (proj),
		.p_last (p_last)
	);

	obe_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.p_valid(p_valid),
		.p_ready(p_ready),
		.proj   (proj),
		.p_last (p_last),
		.margin (cfg_q.margin),
		.b_valid(b_valid),
		.b_ready(b_ready),
		.bb     (bb)
	);

	obe_recentre #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_recentre (
		.clk    (clk),
		.arst_n (arst_n),
		.b_valid(b_valid),
		.b_ready(b_ready),
		.bb     (bb),
		.cfg    (cfg_q),
		.box    (box)
	);
endmodule

FILE: src/obe_project.sv
// Input register, recentring and projection of each point onto the three axes.
// Depends on obe_pkg and points_if; three pipeline stages with per-stage valid.
module obe_project #(
	parameter int COORD_WIDTH = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	points_if.sink           pts,
	input  obe_pkg::cfg_t    cfg,
	output logic             p_valid,
	input  logic             p_ready,
	output obe_pkg::bound3_t proj,
	output logic             p_last
);
	localparam int CW  = COORD_WIDTH;
	localparam int DW  = CW + 1;
	localparam int PW  = DW + obe_pkg::AXIS_W;
	localparam int SW  = PW + 2;
	localparam int RW  = obe_pkg::BOUND_W + 1 + obe_pkg::FRAC_W;
	localparam int EW  = (SW > RW) ? SW : RW;
	localparam int CPW = (3 * CW > obe_pkg::CENTRE_W) ? 3 * CW : obe_pkg::CENTRE_W;
	localparam logic signed [EW-1:0] HALF = EW'(2 ** (obe_pkg::FRAC_W - 1));

	logic                   v_s1, v_s2, v_s3;
	logic                   rdy1, rdy2, rdy3;
	logic                   last_s1, last_s2, last_s3;
	logic signed [CW-1:0]   pt_s1 [3];
	logic signed [PW-1:0]   prod_s2 [3][3];
	obe_pkg::bound3_t       proj_s3;

	logic [CPW-1:0]          cen_pad;
	logic signed [CW-1:0]    cen [3];
	logic signed [DW-1:0]    d [3];
	logic [obe_pkg::AXES_W-1:0] ax [3];
	logic signed [PW-1:0]   prod [3][3];
	logic signed [EW-1:0]   acc [3];
	logic signed [EW-1:0]   sh [3];
	obe_pkg::bound3_t       proj_c;

	function automatic logic [obe_pkg::BOUND_W-1:0] sat_bound(input logic [EW-1:0] v);
		logic [EW-obe_pkg::BOUND_W:0] top;
		top = v[EW-1:obe_pkg::BOUND_W-1];
		if (&top || ~|top)
			return v[obe_pkg::BOUND_W-1:0];
		return v[EW-1] ? obe_pkg::BOUND_MIN : obe_pkg::BOUND_MAX;
	endfunction

	assign rdy3      = !v_s3 || p_ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pts.ready = rdy1;

	assign ax[0]   = cfg.axis_u;
	assign ax[1]   = cfg.axis_v;
	assign ax[2]   = cfg.axis_w;
	assign cen_pad = CPW'(cfg.centre);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cen[j] = cen_pad[j*CW +: CW];
			d[j]   = DW'(pt_s1[j]) - DW'(cen[j]);
		end
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod[k][j] = PW'(obe_pkg::axis_comp(ax[k], j)) * PW'(d[j]);
			end
		end
	end

	// Round half up at 16 fraction bits, then clamp to the bound width.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k]    = EW'(prod_s2[k][0]) + EW'(prod_s2[k][1]) + EW'(prod_s2[k][2]) + HALF;
			sh[k]     = acc[k] >>> obe_pkg::FRAC_W;
			proj_c[k] = sat_bound(sh[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pts.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pts.valid) begin
			pt_s1[0] <= pts.point_x;
			pt_s1[1] <= pts.point_y;
			pt_s1[2] <= pts.point_z;
			last_s1  <= pts.last_point;
		end
		if (rdy2 && v_s1) begin
			prod_s2 <= prod;
			last_s2 <= last_s1;
		end
		if (rdy3 && v_s2) begin
			proj_s3 <= proj_c;
			last_s3 <= last_s2;
		end
	end

	assign p_valid = v_s3;
	assign proj    = proj_s3;
	assign p_last  = last_s3;
endmodule

FILE: src/obe_bounds.sv
// Running minimum and maximum per axis, and margin widening on the last point of a set.
// Depends on obe_pkg and the assertion macros in oriented_box_extent_defines.svh.
`include "oriented_box_extent_defines.svh"

module obe_bounds (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          p_valid,
	output logic                          p_ready,
	input  obe_pkg::bound3_t              proj,
	input  logic                          p_last,
	input  logic [obe_pkg::MARGIN_W-1:0]  margin,
	output logic                          b_valid,
	input  logic                          b_ready,
	output obe_pkg::box_bounds_t          bb
);
	localparam int BW = obe_pkg::BOUND_W;

	obe_pkg::bound3_t run_min_q, run_max_q;
	obe_pkg::bound3_t new_min, new_max;
	obe_pkg::bound3_t lo_c, hi_c, lo_q, hi_q;
	logic             v4_q;
	logic             take;
	logic [BW:0]      lo_t [3];
	logic [BW:0]      hi_t [3];

	// A non-last item only folds into the running bounds; a last one needs the output stage.
	assign p_ready = !p_last || !v4_q || b_ready;
	assign take    = p_valid && p_ready;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			new_min[k] = ($signed(proj[k]) < $signed(run_min_q[k])) ? proj[k] : run_min_q[k];
			new_max[k] = ($signed(proj[k]) > $signed(run_max_q[k])) ? proj[k] : run_max_q[k];
			lo_t[k] = {new_min[k][BW-1], new_min[k]} - (BW+1)'(margin);
			hi_t[k] = {new_max[k][BW-1], new_max[k]} + (BW+1)'(margin);
			if (lo_t[k][BW] != lo_t[k][BW-1])
				lo_c[k] = lo_t[k][BW] ? obe_pkg::BOUND_MIN : obe_pkg::BOUND_MAX;
			else
				lo_c[k] = lo_t[k][BW-1:0];
			if (hi_t[k][BW] != hi_t[k][BW-1])
				hi_c[k] = hi_t[k][BW] ? obe_pkg::BOUND_MIN : obe_pkg::BOUND_MAX;
			else
				hi_c[k] = hi_t[k][BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= {3{obe_pkg::BOUND_MAX}};
			run_max_q <= {3{obe_pkg::BOUND_MIN}};
			v4_q      <= 1'b0;
		end else begin
			if (take) begin
				if (p_last) begin
					run_min_q <= {3{obe_pkg::BOUND_MAX}};
					run_max_q <= {3{obe_pkg::BOUND_MIN}};
				end else begin
					run_min_q <= new_min;
					run_max_q <= new_max;
				end
			end
			if (!v4_q || b_ready) v4_q <= take && p_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && p_last) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
		end
	end

	assign b_valid = v4_q;
	assign bb.lo   = lo_q;
	assign bb.hi   = hi_q;

	`OBE_ASSERT_NEXT(a_run_reset_after_last, take && p_last, run_min_q[0] == obe_pkg::BOUND_MAX && run_max_q[2] == obe_pkg::BOUND_MIN)
	`OBE_ASSERT_NEXT(a_run_hold_when_idle, !take, $stable(run_min_q) && $stable(run_max_q))
	`OBE_ASSERT_IMPL(a_bounds_ordered, v4_q, $signed(lo_q[0]) <= $signed(hi_q[0]) && $signed(lo_q[1]) <= $signed(hi_q[1]) && $signed(lo_q[2]) <= $signed(hi_q[2]))
endmodule

FILE: src/obe_recentre.sv
// Box sizes, midpoint rotated back to world space plus the old centre, and the result register.
// Depends on obe_pkg and box_if.
module obe_recentre #(
	parameter int COORD_WIDTH = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 b_valid,
	output logic                 b_ready,
	input  obe_pkg::box_bounds_t bb,
	input  obe_pkg::cfg_t        cfg,
	box_if.source                box
);
	localparam int CW  = COORD_WIDTH;
	localparam int BW  = obe_pkg::BOUND_W;
	localparam int MW  = BW + 1;
	localparam int MPW = MW + obe_pkg::AXIS_W;
	localparam int MSW = MPW + 2;
	localparam int AW  = (CW + 1 > MSW) ? CW + 1 : MSW;
	localparam int CPW = (3 * CW > obe_pkg::CENTRE_W) ? 3 * CW : obe_pkg::CENTRE_W;
	localparam logic signed [MSW-1:0] HALF = MSW'(2 ** obe_pkg::FRAC_W);

	logic                       v5_q;
	logic                       rdy5, rdy_out;
	logic signed [MPW-1:0]      mprod_s5 [3][3];
	obe_pkg::box_bounds_t       bb_s5;
	logic [obe_pkg::SIZE_W-1:0] size_s5 [2];

	logic [obe_pkg::AXES_W-1:0] ax [3];
	logic signed [MW-1:0]       mid [3];
	logic signed [MPW-1:0]      mprod [3][3];
	logic signed [BW+1:0]       size_t [2];
	logic [obe_pkg::SIZE_W-1:0] size_c [2];
	logic [CPW-1:0]             cen_pad;
	logic signed [CW-1:0]       cen [3];
	logic signed [MSW-1:0]      msum [3];
	logic signed [MSW-1:0]      msh [3];
	logic signed [AW-1:0]       tot [3];
	logic [CW-1:0]              ncen [3];
	logic [AW-CW:0]             top [3];

	assign ax[0]   = cfg.axis_u;
	assign ax[1]   = cfg.axis_v;
	assign ax[2]   = cfg.axis_w;
	assign cen_pad = CPW'(cfg.centre);

	assign rdy_out = !box.valid || box.ready;
	assign rdy5    = !v5_q || rdy_out;
	assign b_ready = rdy5;

	// Midpoint keeps one fraction bit, so the products carry 17; row j of the products gives world coordinate j.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mid[k] = {bb.lo[k][BW-1], bb.lo[k]} + {bb.hi[k][BW-1], bb.hi[k]};
		end
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				mprod[j][k] = MPW'(obe_pkg::axis_comp(ax[k], j)) * MPW'(mid[k]);
			end
		end
		for (int k = 0; k < 2; k++) begin
			size_t[k] = {{2{bb.hi[k][BW-1]}}, bb.hi[k]} - {{2{bb.lo[k][BW-1]}}, bb.lo[k]}
				+ (BW+2)'(cfg.margin);
			if (size_t[k][BW+1])
				size_c[k] = '0;
			else if (|size_t[k][BW:obe_pkg::SIZE_W])
				size_c[k] = obe_pkg::SIZE_MAX;
			else
				size_c[k] = size_t[k][obe_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cen[j]  = cen_pad[j*CW +: CW];
			msum[j] = MSW'(mprod_s5[j][0]) + MSW'(mprod_s5[j][1]) + MSW'(mprod_s5[j][2]) + HALF;
			msh[j]  = msum[j] >>> (obe_pkg::FRAC_W + 1);
			tot[j]  = AW'(msh[j]) + AW'(cen[j]);
			top[j]  = tot[j][AW-1:CW-1];
			if (&top[j] || ~|top[j])
				ncen[j] = tot[j][CW-1:0];
			else
				ncen[j] = tot[j][AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v5_q      <= 1'b0;
			box.valid <= 1'b0;
		end else begin
			if (rdy5)    v5_q      <= b_valid;
			if (rdy_out) box.valid <= v5_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && b_valid) begin
			mprod_s5 <= mprod;
			bb_s5    <= bb;
			size_s5  <= size_c;
		end
		if (rdy_out && v5_q) begin
			box.new_centre_x <= ncen[0];
			box.new_centre_y <= ncen[1];
			box.new_centre_z <= ncen[2];
			box.size_u       <= size_s5[0];
			box.size_v       <= size_s5[1];
			box.low_u        <= bb_s5.lo[0];
			box.low_v        <= bb_s5.lo[1];
			box.low_w        <= bb_s5.lo[2];
			box.high_u       <= bb_s5.hi[0];
			box.high_v       <= bb_s5.hi[1];
			box.high_w       <= bb_s5.hi[2];
		end
	end
endmodule

FILE: tb/tb_oriented_box_extent.sv
// Self-checking testbench for oriented_box_extent: streams point sets, predicts each box.
// Depends on obe_pkg, points_if, box_if, cfg_if and the oriented_box_extent RTL.
// Driver and monitor are clocked processes; the main initial block queues points per setting.
module tb_oriented_box_extent;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_W     = obe_pkg::FRAC_W;
	localparam int AXIS_W     = obe_pkg::AXIS_W;
	localparam int AXES_W     = obe_pkg::AXES_W;
	localparam int CENTRE_W   = obe_pkg::CENTRE_W;
	localparam int MARGIN_W   = obe_pkg::MARGIN_W;
	localparam int BOUND_W    = obe_pkg::BOUND_W;
	localparam int SIZE_W     = obe_pkg::SIZE_W;
	localparam int CFG_IDX_W  = obe_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = obe_pkg::CFG_DATA_W;

	localparam int CW = 21;
	localparam longint COORD_TOP = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint COORD_BOT = -COORD_TOP - 1;
	localparam longint AXIS_TOP  = (longint'(1) <<< (AXIS_W - 1)) - 1;
	localparam longint AXIS_BOT  = -AXIS_TOP - 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int SET_POINTS   = 150;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0]      centre_x;
		logic signed [CW-1:0]      centre_y;
		logic signed [CW-1:0]      centre_z;
		logic [SIZE_W-1:0]         size_u;
		logic [SIZE_W-1:0]         size_v;
		logic signed [BOUND_W-1:0] low_u;
		logic signed [BOUND_W-1:0] low_v;
		logic signed [BOUND_W-1:0] low_w;
		logic signed [BOUND_W-1:0] high_u;
		logic signed [BOUND_W-1:0] high_v;
		logic signed [BOUND_W-1:0] high_w;
	} box_t;

	logic clk;
	logic arst_n;

	points_if #(.COORD_WIDTH(CW)) pts_ch ();
	box_if #(.COORD_WIDTH(CW))    box_ch ();
	cfg_if                        cfg_ch ();

	oriented_box_extent #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts_ch),
		.box(box_ch),
		.cfg(cfg_ch)
	);

	// Shadow registers and running bounds of the block
	obe_pkg::cfg_t regs;
	longint        run_lo[3];
	longint        run_hi[3];

	point_t points_due[$];
	box_t   boxes_due[$];
	point_t offer;
	point_t next_pt;
	int     mismatches = 0;
	int     stall_left;
	bit     sender_calm;
	bit     receiver_calm;
	bit     stall_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint sat(longint v, int w);
		longint top;
		top = (longint'(1) <<< (w - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic longint axis_coef(logic [AXES_W-1:0] a, int j);
		logic signed [AXIS_W-1:0] c;
		c = a[j*AXIS_W +: AXIS_W];
		return longint'(c);
	endfunction

	function automatic longint centre_coord(int j);
		logic signed [CW-1:0] c;
		c = regs.centre[j*CW +: CW];
		return longint'(c);
	endfunction

	function automatic longint clamp_size(longint lo, longint hi, longint m);
		longint s;
		longint top;
		s = hi - lo + m;
		top = (longint'(1) <<< SIZE_W) - 1;
		if (s < 0)
			return 0;
		if (s > top)
			return top;
		return s;
	endfunction

	function automatic void clear_bounds();
		for (int i = 0; i < 3; i++) begin
			run_lo[i] = (longint'(1) <<< (BOUND_W - 1)) - 1;
			run_hi[i] = -(longint'(1) <<< (BOUND_W - 1));
		end
	endfunction

	// Project one point into the running bounds; on a last point queue the box it closes.
	function automatic void take_point(point_t p);
		logic [AXES_W-1:0] ax[3];
		longint d[3];
		longint lo[3];
		longint hi[3];
		longint mid[3];
		longint cen[3];
		longint acc;
		longint proj;
		longint m;
		box_t r;
		ax[0] = regs.axis_u;
		ax[1] = regs.axis_v;
		ax[2] = regs.axis_w;
		d[0] = longint'(p.x) - centre_coord(0);
		d[1] = longint'(p.y) - centre_coord(1);
		d[2] = longint'(p.z) - centre_coord(2);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += axis_coef(ax[i], j) * d[j];
			proj = sat((acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W, BOUND_W);
			if (proj < run_lo[i])
				run_lo[i] = proj;
			if (proj > run_hi[i])
				run_hi[i] = proj;
		end
		if (!p.last)
			return;
		m = longint'(regs.margin);
		for (int i = 0; i < 3; i++) begin
			lo[i] = sat(run_lo[i] - m, BOUND_W);
			hi[i] = sat(run_hi[i] + m, BOUND_W);
			mid[i] = lo[i] + hi[i];
		end
		// midpoint carries one extra fraction bit; round half up from Q.17 back to Q.0
		for (int j = 0; j < 3; j++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += axis_coef(ax[i], j) * mid[i];
			acc = (acc + (longint'(1) <<< FRAC_W)) >>> (FRAC_W + 1);
			cen[j] = sat(acc + centre_coord(j), CW);
		end
		r.centre_x = CW'(cen[0]);
		r.centre_y = CW'(cen[1]);
		r.centre_z = CW'(cen[2]);
		r.size_u   = SIZE_W'(clamp_size(lo[0], hi[0], m));
		r.size_v   = SIZE_W'(clamp_size(lo[1], hi[1], m));
		r.low_u    = BOUND_W'(lo[0]);
		r.low_v    = BOUND_W'(lo[1]);
		r.low_w    = BOUND_W'(lo[2]);
		r.high_u   = BOUND_W'(hi[0]);
		r.high_v   = BOUND_W'(hi[1]);
		r.high_w   = BOUND_W'(hi[2]);
		boxes_due = {boxes_due, r};
		clear_bounds();
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
		end
	endfunction

	function automatic void check_box();
		box_t got;
		box_t want;
		got.centre_x = box_ch.new_centre_x;
		got.centre_y = box_ch.new_centre_y;
		got.centre_z = box_ch.new_centre_z;
		got.size_u   = box_ch.size_u;
		got.size_v   = box_ch.size_v;
		got.low_u    = box_ch.low_u;
		got.low_v    = box_ch.low_v;
		got.low_w    = box_ch.low_w;
		got.high_u   = box_ch.high_u;
		got.high_v   = box_ch.high_v;
		got.high_w   = box_ch.high_w;
		if (boxes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: box item with none expected, centre %0d %0d %0d",
					$realtime, got.centre_x, got.centre_y, got.centre_z);
			return;
		end
		want = boxes_due.pop_front();
		check_field("new_centre_x", want.centre_x, got.centre_x);
		check_field("new_centre_y", want.centre_y, got.centre_y);
		check_field("new_centre_z", want.centre_z, got.centre_z);
		check_field("size_u", want.size_u, got.size_u);
		check_field("size_v", want.size_v, got.size_v);
		check_field("low_u", want.low_u, got.low_u);
		check_field("low_v", want.low_v, got.low_v);
		check_field("low_w", want.low_w, got.low_w);
		check_field("high_u", want.high_u, got.high_u);
		check_field("high_v", want.high_v, got.high_v);
		check_field("high_w", want.high_w, got.high_w);
	endfunction

	// Point driver: hold an offered item until taken, then advance or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			pts_ch.valid      <= 1'b0;
			pts_ch.point_x    <= '0;
			pts_ch.point_y    <= '0;
			pts_ch.point_z    <= '0;
			pts_ch.last_point <= 1'b0;
		end else begin
			if (pts_ch.valid && pts_ch.ready)
				take_point(offer);
			if (!pts_ch.valid || pts_ch.ready) begin
				if (points_due.size() != 0 && (sender_calm || $urandom_range(0, 99) >= 36)) begin
					next_pt = points_due.pop_front();
					offer             <= next_pt;
					pts_ch.valid      <= 1'b1;
					pts_ch.point_x    <= next_pt.x;
					pts_ch.point_y    <= next_pt.y;
					pts_ch.point_z    <= next_pt.z;
					pts_ch.last_point <= next_pt.last;
				end else begin
					pts_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Box monitor: check taken items, drive ready with random and long stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			box_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (box_ch.valid && box_ch.ready)
				check_box();
			if (stall_req) begin
				stall_left   <= STALL_CYCLES;
				box_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				box_ch.ready <= 1'b0;
			end else begin
				box_ch.ready <= receiver_calm || $urandom_range(0, 99) >= 36;
			end
		end
	end

	// Called at a rising edge; leaves valid high for a following write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			obe_pkg::REG_AXIS_U:     regs.axis_u = val[AXES_W-1:0];
			obe_pkg::REG_AXIS_V:     regs.axis_v = val[AXES_W-1:0];
			obe_pkg::REG_AXIS_W:     regs.axis_w = val[AXES_W-1:0];
			obe_pkg::REG_BOX_CENTRE: regs.centre = val[CENTRE_W-1:0];
			obe_pkg::REG_MARGIN:     regs.margin = val[MARGIN_W-1:0];
			default: ;
		endcase
	endtask

	// Fill the bits above a register's width with noise.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] field, int w);
		logic [CFG_DATA_W-1:0] r;
		logic [CFG_DATA_W-1:0] mask;
		r = {$urandom, $urandom};
		mask = (64'd1 << w) - 64'd1;
		return (r & ~mask) | (field & mask);
	endfunction

	task automatic load_settings(logic [AXES_W-1:0] au, logic [AXES_W-1:0] av,
			logic [AXES_W-1:0] aw, logic [CENTRE_W-1:0] ctr, logic [MARGIN_W-1:0] mg,
			bit poke_spare);
		@(posedge clk);
		write_reg(obe_pkg::REG_AXIS_U, with_junk(CFG_DATA_W'(au), AXES_W));
		write_reg(obe_pkg::REG_AXIS_V, with_junk(CFG_DATA_W'(av), AXES_W));
		write_reg(obe_pkg::REG_AXIS_W, with_junk(CFG_DATA_W'(aw), AXES_W));
		write_reg(obe_pkg::REG_BOX_CENTRE, with_junk(CFG_DATA_W'(ctr), CENTRE_W));
		write_reg(obe_pkg::REG_MARGIN, with_junk(CFG_DATA_W'(mg), MARGIN_W));
		if (poke_spare)
			write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [AXES_W-1:0] pack_axis(longint x, longint y, longint z);
		return {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
	endfunction

	function automatic logic [CENTRE_W-1:0] pack_centre(longint x, longint y, longint z);
		return {CW'(z), CW'(y), CW'(x)};
	endfunction

	function automatic logic [AXES_W-1:0] rand_axis(bit narrow);
		if (narrow)
			return pack_axis(longint'($urandom_range(0, 131072)) - 65536,
				longint'($urandom_range(0, 131072)) - 65536,
				longint'($urandom_range(0, 131072)) - 65536);
		return pack_axis(longint'($urandom), longint'($urandom), longint'($urandom));
	endfunction

	function automatic void add_point(longint x, longint y, longint z, bit last);
		point_t p;
		p.x = CW'(x);
		p.y = CW'(y);
		p.z = CW'(z);
		p.last = last;
		points_due = {points_due, p};
	endfunction

	function automatic longint pick_coord(int style, longint base, longint spread);
		case (style)
			0: return longint'($urandom);
			1: return base + longint'($urandom_range(0, 2 * spread)) - spread;
			2: begin
				case ($urandom_range(0, 3))
					0: return COORD_TOP;
					1: return COORD_BOT;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return longint'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	// Queue whole point sets, each closed by a last point, until count points are queued.
	function automatic void queue_sets(int count, bit short_sets);
		int n;
		int len;
		int pick;
		int style;
		longint spread;
		longint base[3];
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 9);
			if (short_sets)
				len = $urandom_range(1, 3);
			else if (pick < 5)
				len = $urandom_range(1, 4);
			else if (pick < 8)
				len = $urandom_range(5, 16);
			else
				len = $urandom_range(17, 40);
			style = $urandom_range(0, 3);
			spread = longint'(1) <<< $urandom_range(2, 18);
			for (int j = 0; j < 3; j++)
				base[j] = longint'($urandom_range(0, 2097151)) + COORD_BOT;
			for (int k = 0; k < len; k++) begin
				add_point(pick_coord(style, base[0], spread), pick_coord(style, base[1], spread),
					pick_coord(style, base[2], spread), k == len - 1);
				n++;
			end
		end
	endfunction

	task automatic wait_quiet();
		while (points_due.size() != 0 || boxes_due.size() != 0 || pts_ch.valid)
			@(negedge clk);
	endtask

	task automatic settle();
		wait_quiet();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [AXES_W-1:0]   au;
		logic [AXES_W-1:0]   av;
		logic [AXES_W-1:0]   aw;
		logic [CENTRE_W-1:0] ctr;
		logic [MARGIN_W-1:0] mg;

		arst_n        = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		stall_req     = 1'b0;
		regs = '{axis_u: obe_pkg::AXIS_U_RST, axis_v: obe_pkg::AXIS_V_RST,
			axis_w: obe_pkg::AXIS_W_RST, centre: obe_pkg::CENTRE_RST,
			margin: obe_pkg::MARGIN_RST};
		clear_bounds();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points under reset settings: extremes, mixed sets, half-LSB rounding
		add_point(0, 0, 0, 1'b1);
		add_point(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1);
		add_point(COORD_BOT, COORD_BOT, COORD_BOT, 1'b1);
		add_point(COORD_TOP, COORD_BOT, 0, 1'b0);
		add_point(COORD_BOT, COORD_TOP, 0, 1'b0);
		add_point(0, 0, COORD_TOP, 1'b0);
		add_point(0, 0, COORD_BOT, 1'b1);
		add_point(1, -1, 1, 1'b1);
		add_point(-1, 1, -1, 1'b1);
		add_point(0, 2, 0, 1'b1);
		add_point(0, -2, 0, 1'b1);
		add_point(0, 6, 8, 1'b1);
		add_point(1398101, 699050, 1398101, 1'b0);
		add_point(699050, 1398101, 699050, 1'b1);
		repeat (5) add_point(12345, -23456, 34567, 1'b0);
		add_point(12345, -23456, 34567, 1'b1);
		settle();

		for (int ph = 1; ph <= 7; ph++) begin
			case (ph)
				1: begin
					au = pack_axis(65536, 0, 0);
					av = pack_axis(0, 65536, 0);
					aw = pack_axis(0, 0, 65536);
					ctr = pack_centre(longint'($urandom_range(0, 131072)) - 65536,
						longint'($urandom_range(0, 131072)) - 65536,
						longint'($urandom_range(0, 131072)) - 65536);
					mg = '0;
				end
				2: begin
					au = rand_axis(1'b0);
					av = rand_axis(1'b0);
					aw = rand_axis(1'b0);
					ctr = CENTRE_W'({$urandom, $urandom});
					mg = '1;
				end
				3: begin
					au = pack_axis(AXIS_BOT, AXIS_BOT, AXIS_BOT);
					av = au;
					aw = au;
					ctr = pack_centre(COORD_BOT, COORD_BOT, COORD_BOT);
					mg = '1;
				end
				4: begin
					au = pack_axis(AXIS_TOP, AXIS_TOP, AXIS_TOP);
					av = au;
					aw = pack_axis(AXIS_BOT, AXIS_TOP, AXIS_BOT);
					ctr = pack_centre(COORD_TOP, COORD_TOP, COORD_TOP);
					mg = '0;
				end
				default: begin
					au = rand_axis(ph != 7);
					av = rand_axis(ph != 7);
					aw = rand_axis(ph != 7);
					ctr = CENTRE_W'({$urandom, $urandom});
					mg = MARGIN_W'($urandom);
				end
			endcase
			load_settings(au, av, aw, ctr, mg, ph == 6);
			case (ph)
				2: begin
					// no idling on either side for the whole setting
					sender_calm = 1'b1;
					receiver_calm = 1'b1;
					queue_sets(SET_POINTS, 1'b0);
					wait_quiet();
					sender_calm = 1'b0;
					receiver_calm = 1'b0;
				end
				3: begin
					// hold the output off while short sets keep coming to back up the pipeline
					sender_calm = 1'b1;
					queue_sets(SET_POINTS, 1'b1);
					stall_req = 1'b1;
					@(negedge clk);
					stall_req = 1'b0;
					wait_quiet();
					sender_calm = 1'b0;
				end
				4: begin
					// pause mid-set until every queued box is out, then finish the set
					queue_sets(SET_POINTS / 2, 1'b0);
					add_point(longint'($urandom), longint'($urandom), longint'($urandom), 1'b0);
					add_point(longint'($urandom), longint'($urandom), longint'($urandom), 1'b0);
					add_point(longint'($urandom), longint'($urandom), longint'($urandom), 1'b0);
					wait_quiet();
					queue_sets(SET_POINTS / 2, 1'b0);
				end
				default: queue_sets(SET_POINTS, 1'b0);
			endcase
			settle();
		end

		if (mismatches == 0 && boxes_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
